// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file spc_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define SPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spc assertion failed");

// property checked at every edge, reset included
`define SPC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("spc assertion failed");

`endif

// ===== rtl/spc_pkg.sv =====
// types and constants of the spanned point counter
// no dependencies
`timescale 1ns / 1ps

package spc_pkg;

    localparam int unsigned CHROM_W = 10;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned HIT_W   = 13;
    localparam int unsigned CFG_W   = 16;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_PROC   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] REG_OVH_LEFT  = 2'd0;
    localparam logic [1:0] REG_OVH_RIGHT = 2'd1;
    localparam logic [1:0] REG_ENTRIES   = 2'd2;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [1:0]         command;
        logic [11:0]        entry_index;
        logic [CHROM_W-1:0] chromosome;
        logic [31:0]        position;
        logic [31:0]        block_length;
        logic               strand;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0] strand_count;
        logic [CNT_W-1:0] total_count;
        logic             found;
        logic [HIT_W-1:0] points_hit;
    } t_out_word;

    typedef struct packed {
        logic [15:0] ovh_left;
        logic [15:0] ovh_right;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/spc_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module spc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== rtl/spc_cfg_regs.sv =====
// configuration registers, entry count clamped to the table depth
// depends on spc_pkg
`timescale 1ns / 1ps

module spc_cfg_regs #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [spc_pkg::CFG_W-1:0]        i_cfg_data,
    output spc_pkg::t_cfg                    o_cfg,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_entries
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    spc_pkg::t_cfg r_cfg;
    logic [12:0]   r_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_entries <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spc_pkg::REG_OVH_LEFT:  r_cfg.ovh_left  <= i_cfg_data;
                spc_pkg::REG_OVH_RIGHT: r_cfg.ovh_right <= i_cfg_data;
                spc_pkg::REG_ENTRIES:   r_entries <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign o_cfg     = r_cfg;
    assign o_entries = (32'(r_entries) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(r_entries);

endmodule

// ===== rtl/spanned_point_counter.sv =====
// spanned point counter: loads go straight to the rams, scans read one entry per cycle
// a load is written to the rams as it is accepted; process and lookup scan the entries in use
// a lookup stops its scan at the first slot that matches
// short blocks, an empty table and unknown commands skip the scan like a load
// one word at a time: the next is taken the cycle after the result is registered
// synchronous active-low reset clears control state; table contents undefined
`timescale 1ns / 1ps

module spanned_point_counter #(
    parameter int TABLE_DEPTH = 4096,
    parameter int CHROM_BITS  = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [spc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  spc_pkg::t_in_word         i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output spc_pkg::t_out_word        o_out_word
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int CB = CHROM_BITS;
    localparam int NW = spc_pkg::CNT_W;

    spc_pkg::t_cfg     cfg;
    logic [CW-1:0]     entries;

    spc_pkg::t_state   r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [CB-1:0]     r_chrom, n_chrom;
    logic [31:0]       r_pos, n_pos;
    logic [32:0]       r_lo, n_lo;
    logic [32:0]       r_hi, n_hi;
    logic              r_strand, n_strand;
    logic [CW-1:0]     r_addr, n_addr;
    logic              r_rd_vld, n_rd_vld;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic              r_stop, n_stop;
    spc_pkg::t_out_word r_res, n_res;
    logic              r_out_vld, n_out_vld;
    spc_pkg::t_out_word r_out_word, n_out_word;

    logic              pt_we, cnt_we;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [CB+31:0]    pt_wdata, pt_q;
    logic [2*NW-1:0]   cnt_wdata, cnt_q;
    logic [CB-1:0]     in_chrom;
    logic [16:0]       need;
    logic              issue, hit, lk_hit, slot_ok;
    logic [NW-1:0]     q_plus, q_minus, inc_plus, inc_minus;
    logic [NW:0]       sum;

    spc_cfg_regs #(.TABLE_DEPTH(TABLE_DEPTH)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_entries  (entries)
    );

    // {chromosome, position}
    spc_ram #(.WIDTH(CB + 32), .DEPTH(TABLE_DEPTH)) u_pt_ram (
        .i_clk     (i_clk),
        .i_we      (pt_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (pt_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (pt_q)
    );

    // {plus, minus}
    spc_ram #(.WIDTH(2 * NW), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_we      (cnt_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (cnt_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (cnt_q)
    );

    assign in_chrom  = CB'(i_in_word.chromosome);
    assign need      = {1'b0, cfg.ovh_left} + {1'b0, cfg.ovh_right};
    assign slot_ok   = 32'(i_in_word.entry_index) < 32'(TABLE_DEPTH);
    assign q_plus    = cnt_q[2*NW-1:NW];
    assign q_minus   = cnt_q[NW-1:0];
    assign inc_plus  = (q_plus == spc_pkg::CNT_MAX) ? q_plus : q_plus + 1'b1;
    assign inc_minus = (q_minus == spc_pkg::CNT_MAX) ? q_minus : q_minus + 1'b1;
    assign sum       = {1'b0, q_plus} + {1'b0, q_minus};

    assign issue  = (r_state == spc_pkg::ST_SCAN) && (r_addr < entries) && !r_stop;
    assign rd_addr = r_addr[AW-1:0];
    assign hit    = r_rd_vld && (pt_q[CB+31:32] == r_chrom)
                    && ({1'b0, pt_q[31:0]} >= r_lo) && ({1'b0, pt_q[31:0]} < r_hi);
    assign lk_hit = r_rd_vld && !r_stop && (pt_q[CB+31:32] == r_chrom)
                    && (pt_q[31:0] == r_pos);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_chrom    = r_chrom;
        n_pos      = r_pos;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_strand   = r_strand;
        n_addr     = r_addr;
        n_rd_vld   = issue;
        n_rd_addr  = r_addr[AW-1:0];
        n_stop     = r_stop;
        n_res      = r_res;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_word = r_out_word;
        pt_we      = 1'b0;
        cnt_we     = 1'b0;
        wr_addr    = r_rd_addr;
        pt_wdata   = {in_chrom, i_in_word.position};
        cnt_wdata  = r_strand ? {inc_plus, q_minus} : {q_plus, inc_minus};
        o_in_stall = r_state != spc_pkg::ST_IDLE;

        case (r_state)
            spc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_word.command;
                    n_chrom  = in_chrom;
                    n_pos    = i_in_word.position;
                    n_lo     = {1'b0, i_in_word.position} + 33'(cfg.ovh_left);
                    n_hi     = {1'b0, i_in_word.position} + {1'b0, i_in_word.block_length};
                    n_strand = i_in_word.strand;
                    n_addr   = '0;
                    n_stop   = 1'b0;
                    n_res    = '0;
                    n_state  = spc_pkg::ST_FIN;
                    case (i_in_word.command)
                        spc_pkg::CMD_LOAD: begin
                            wr_addr   = AW'(i_in_word.entry_index);
                            pt_we     = slot_ok;
                            cnt_we    = slot_ok;
                            cnt_wdata = '0;
                        end
                        spc_pkg::CMD_PROC: begin
                            if (i_in_word.block_length > 32'(need) && entries != '0) begin
                                n_state = spc_pkg::ST_SCAN;
                            end
                        end
                        spc_pkg::CMD_LOOKUP: begin
                            if (entries != '0) begin
                                n_state = spc_pkg::ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            spc_pkg::ST_SCAN: begin
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_cmd == spc_pkg::CMD_PROC) begin
                    if (hit) begin
                        cnt_we = 1'b1;
                        if (r_res.points_hit != spc_pkg::HIT_MAX) begin
                            n_res.points_hit = r_res.points_hit + 1'b1;
                        end
                    end
                end else if (lk_hit) begin
                    n_stop             = 1'b1;
                    n_res.found        = 1'b1;
                    n_res.strand_count = r_strand ? q_plus : q_minus;
                    n_res.total_count  = sum[NW] ? spc_pkg::CNT_MAX : sum[NW-1:0];
                end
                if (!issue && !r_rd_vld) begin
                    n_state = spc_pkg::ST_FIN;
                end
            end
            spc_pkg::ST_FIN: begin
                // wait for the output register to free up
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_word = r_res;
                    n_state    = spc_pkg::ST_IDLE;
                end
            end
            default: n_state = spc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spc_pkg::ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_stop    <= 1'b0;
            r_out_vld <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_stop    <= n_stop;
            r_out_vld <= n_out_vld;
            r_addr    <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_chrom    <= n_chrom;
        r_pos      <= n_pos;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_strand   <= n_strand;
        r_rd_addr  <= n_rd_addr;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/spc_checker.sv =====
// port-level checks of the spanned point counter, bound to the top level
// depends on spc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input spc_pkg::t_out_word o_out_word,
    input logic               i_in_valid,
    input logic               o_in_stall
);

    // a stalled word stays
    `SPC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)
    // the block is busy right after taking a word
    `SPC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)
    // a found word never carries a hit count
    `SPC_ASSERT(a_found_no_hits, i_clk, i_rst_n, o_out_valid && o_out_word.found |-> o_out_word.points_hit == '0)
    // reset empties the output
    `SPC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind spanned_point_counter spc_checker u_spc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall)
);

// ===== tb/spanned_point_counter_test.sv =====
// testbench for spanned_point_counter: directed table, random phases and a calm stretch
// of long scans; checked against an in-bench predictor; depends on spc_pkg and the rtl top
`timescale 1ns / 1ps

module spanned_point_counter_test;

    localparam int DEPTH = 4096;
    localparam int N_ITEMS = 1950;
    localparam int FILL = 300;
    localparam int CHW = spc_pkg::CHROM_W;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         reg_idx;
        logic [15:0]        reg_val;
        spc_pkg::t_in_word  w;
        bit                 typed;
        spc_pkg::t_out_word exp_word;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [1:0]                i_cfg_idx = spc_pkg::REG_OVH_LEFT;
    logic [spc_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    spc_pkg::t_in_word         i_in_word = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    spc_pkg::t_out_word        o_out_word;

    // mirror of the table and registers
    logic [31:0]        pt_pos[DEPTH];
    logic [CHW-1:0]     pt_chrom[DEPTH];
    logic [31:0]        plus_cnt[DEPTH];
    logic [31:0]        minus_cnt[DEPTH];
    bit                 slot_loaded[DEPTH];
    logic [15:0]        ovh_left = '0;
    logic [15:0]        ovh_right = '0;
    logic [12:0]        n_entries = '0;

    spc_pkg::t_out_word expected_words[$];
    t_row               dir_rows[$];
    int                 mismatches = 0;
    int                 words_sent = 0;
    bit                 calm = 1'b0;

    spanned_point_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic spc_pkg::t_in_word mk_word(logic [1:0] c, logic [11:0] s,
                                                  logic [CHW-1:0] ch, logic [31:0] p,
                                                  logic [31:0] l, logic st);
        spc_pkg::t_in_word w;
        w.command = c;
        w.entry_index = s;
        w.chromosome = ch;
        w.position = p;
        w.block_length = l;
        w.strand = st;
        return w;
    endfunction

    // updates the mirror and returns the word the block should answer with
    function automatic spc_pkg::t_out_word count_spanned(spc_pkg::t_in_word w);
        spc_pkg::t_out_word r;
        logic [32:0] need;
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] sum;
        int          n;
        int          hits;
        bit          hit_found;
        r = '0;
        n = (n_entries > DEPTH) ? DEPTH : int'(n_entries);
        case (w.command)
            spc_pkg::CMD_LOAD: begin
                pt_pos[w.entry_index] = w.position;
                pt_chrom[w.entry_index] = w.chromosome;
                plus_cnt[w.entry_index] = '0;
                minus_cnt[w.entry_index] = '0;
                slot_loaded[w.entry_index] = 1'b1;
            end
            spc_pkg::CMD_PROC: begin
                need = {17'b0, ovh_left} + {17'b0, ovh_right};
                hits = 0;
                if ({1'b0, w.block_length} > need) begin
                    lo = {1'b0, w.position} + {17'b0, ovh_left};
                    hi = {1'b0, w.position} + {1'b0, w.block_length};
                    for (int i = 0; i < n; i++) begin
                        if (pt_chrom[i] == w.chromosome && {1'b0, pt_pos[i]} >= lo &&
                            {1'b0, pt_pos[i]} < hi) begin
                            if (w.strand) begin
                                if (plus_cnt[i] != spc_pkg::CNT_MAX) plus_cnt[i]++;
                            end else begin
                                if (minus_cnt[i] != spc_pkg::CNT_MAX) minus_cnt[i]++;
                            end
                            if (hits < int'(spc_pkg::HIT_MAX)) hits++;
                        end
                    end
                end
                r.points_hit = hits[spc_pkg::HIT_W-1:0];
            end
            spc_pkg::CMD_LOOKUP: begin
                hit_found = 1'b0;
                for (int i = 0; i < n && !hit_found; i++) begin
                    if (pt_chrom[i] == w.chromosome && pt_pos[i] == w.position) begin
                        hit_found = 1'b1;
                        sum = {1'b0, plus_cnt[i]} + {1'b0, minus_cnt[i]};
                        r.strand_count = w.strand ? plus_cnt[i] : minus_cnt[i];
                        r.total_count = sum[32] ? spc_pkg::CNT_MAX : sum[31:0];
                        r.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(spc_pkg::t_in_word w, bit typed, spc_pkg::t_out_word typed_exp);
        spc_pkg::t_out_word p;
        while (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = count_spanned(w);
        expected_words = {expected_words, (typed ? typed_exp : p)};
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_plain(spc_pkg::t_in_word w);
        send_word(w, 1'b0, '0);
    endtask

    // hold the sender until every answer is back and the block is quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            spc_pkg::REG_OVH_LEFT:  ovh_left = val;
            spc_pkg::REG_OVH_RIGHT: ovh_right = val;
            spc_pkg::REG_ENTRIES:   n_entries = val[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void add_item(spc_pkg::t_in_word w, bit typed);
        t_row r;
        r.is_cfg = 1'b0;
        r.reg_idx = spc_pkg::REG_OVH_LEFT;
        r.reg_val = '0;
        r.w = w;
        r.typed = typed;
        r.exp_word = '0;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [15:0] val);
        t_row r;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.w = '0;
        r.typed = 1'b0;
        r.exp_word = '0;
        dir_rows = {dir_rows, r};
    endfunction

    // one random phase: fresh overhangs, fresh points, then mixed traffic
    task automatic run_phase();
        logic [CHW-1:0]     c0;
        logic [CHW-1:0]     c1;
        logic [CHW-1:0]     ch;
        logic [31:0]        base;
        logic [31:0]        start;
        logic [31:0]        len;
        int                 step;
        int                 npts;
        int                 half;
        int                 prefix;
        int                 m;
        int                 k;
        int                 j;
        c0 = ($urandom_range(3) == 0) ? CHW'($urandom_range(1023)) : CHW'($urandom_range(3));
        c1 = ($urandom_range(3) == 0) ? CHW'($urandom_range(1023)) : CHW'($urandom_range(3));
        k = $urandom_range(9);
        base = (k == 0) ? 32'hFFFF_FFFF - 32'd3000 : (k == 1) ? 32'd0 : $urandom;
        step = $urandom_range(1, 40);
        npts = $urandom_range(1, 32);
        half = npts / 2;
        cfg_write(spc_pkg::REG_OVH_LEFT,
                  ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom_range(15)));
        cfg_write(spc_pkg::REG_OVH_RIGHT,
                  ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom_range(15)));
        for (int i = 0; i < npts; i++) begin
            ch = (i < half) ? c0 : c1;
            send_plain(mk_word(spc_pkg::CMD_LOAD, 12'(i), ch,
                               base + 32'((i < half ? i : i - half) * step),
                               $urandom, 1'($urandom)));
        end
        prefix = 0;
        while (prefix < DEPTH && slot_loaded[prefix]) prefix++;
        cfg_write(spc_pkg::REG_ENTRIES,
                  ($urandom_range(9) == 0) ? 16'($urandom_range(prefix)) : 16'(npts));
        m = $urandom_range(20, 60);
        for (int i = 0; i < m; i++) begin
            k = $urandom_range(99);
            ch = $urandom_range(1) ? c0 : c1;
            if (k < 50) begin
                start = base + 32'($urandom_range(npts * step)) - 32'($urandom_range(30));
                if ($urandom_range(9) == 0)
                    len = 32'($urandom_range({16'b0, ovh_left} + {16'b0, ovh_right}));
                else if ($urandom_range(19) == 0)
                    len = $urandom;
                else
                    len = 32'(ovh_left) + 32'(ovh_right) +
                          32'($urandom_range(1, npts * step + 60));
                send_plain(mk_word(spc_pkg::CMD_PROC, 12'($urandom), ch, start, len,
                                   1'($urandom)));
            end else if (k < 80) begin
                j = $urandom_range(npts - 1);
                if ($urandom_range(7) == 0)
                    send_plain(mk_word(spc_pkg::CMD_LOOKUP, 12'($urandom), ch,
                                       base + 32'($urandom_range(99)),
                                       $urandom, 1'($urandom)));
                else
                    send_plain(mk_word(spc_pkg::CMD_LOOKUP, 12'($urandom), pt_chrom[j],
                                       pt_pos[j], $urandom, 1'($urandom)));
            end else if (k < 90) begin
                send_plain(mk_word(spc_pkg::CMD_LOAD, 12'($urandom_range(npts - 1)), ch,
                                   base + 32'($urandom_range(npts * step)), $urandom,
                                   1'($urandom)));
            end else begin
                send_plain(mk_word(2'($urandom), 12'($urandom), CHW'($urandom), $urandom,
                                   $urandom, 1'($urandom)));
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
    end

    always @(posedge i_clk) begin
        spc_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: count %0d total %0d found %0d hits %0d",
                             o_out_word.strand_count, o_out_word.total_count,
                             o_out_word.found, o_out_word.points_hit);
            end else begin
                e = expected_words.pop_front();
                if (e.strand_count !== o_out_word.strand_count ||
                    e.total_count !== o_out_word.total_count ||
                    e.found !== o_out_word.found || e.points_hit !== o_out_word.points_hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 e.strand_count, e.total_count, e.found, e.points_hit,
                                 o_out_word.strand_count, o_out_word.total_count,
                                 o_out_word.found, o_out_word.points_hit);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("FAIL spanned_point_counter");
        $finish;
    end

    initial begin
        // empty table, unknown command, loads with duplicates and an unsorted tail
        add_cfg(spc_pkg::REG_OVH_LEFT, 16'd0);
        add_cfg(spc_pkg::REG_OVH_RIGHT, 16'd0);
        add_cfg(spc_pkg::REG_ENTRIES, 16'd0);
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'd0, 32'd0, 32'hFFFF_FFFF, 1'b1), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOOKUP, 12'd0, 10'd0, 32'd0, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(CMD_UNUSED, 12'hFFF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
                 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd0, 10'd0, 32'd0, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd1, 10'd0, 32'd100, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd2, 10'd0, 32'd100, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd3, 10'd0, 32'd200, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd4, 10'h3FF, 32'hFFFF_FFF0, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd5, 10'h3FF, 32'hFFFF_FFFF, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd6, 10'd5, 32'd50, 32'd0, 1'b0), 1'b1);
        add_item(mk_word(spc_pkg::CMD_LOAD, 12'd7, 10'd5, 32'd10, 32'd0, 1'b0), 1'b1);
        add_cfg(spc_pkg::REG_ENTRIES, 16'd8);
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'd0, 32'd0, 32'hFFFF_FFFF, 1'b1), 1'b0);
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'd0, 32'd100, 32'd1, 1'b0), 1'b0);
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'h3FF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1),
                 1'b0);
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'd5, 32'd0, 32'd60, 1'b0), 1'b0);
        add_cfg(spc_pkg::REG_OVH_LEFT, 16'hFFFF);
        add_cfg(spc_pkg::REG_OVH_RIGHT, 16'hFFFF);
        // length equal to the overhang sum is too short
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'd0, 32'd0, 32'd131070, 1'b1), 1'b1);
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'd0, 32'd0, 32'd131071, 1'b1), 1'b0);
        add_cfg(spc_pkg::REG_OVH_LEFT, 16'd10);
        add_cfg(spc_pkg::REG_OVH_RIGHT, 16'd0);
        add_item(mk_word(spc_pkg::CMD_PROC, 12'd0, 10'd0, 32'd90, 32'd200, 1'b0), 1'b0);
        add_item(mk_word(spc_pkg::CMD_LOOKUP, 12'd0, 10'd0, 32'd100, 32'd0, 1'b1), 1'b0);
        add_item(mk_word(spc_pkg::CMD_LOOKUP, 12'd0, 10'h3FF, 32'hFFFF_FFFF, 32'd0, 1'b0), 1'b0);
        add_item(mk_word(spc_pkg::CMD_LOOKUP, 12'd0, 10'd5, 32'd10, 32'd0, 1'b0), 1'b0);
        add_item(mk_word(spc_pkg::CMD_LOOKUP, 12'd0, 10'd0, 32'd300, 32'd0, 1'b1), 1'b1);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg)
                cfg_write(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            else
                send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].exp_word);
        end

        while (words_sent < N_ITEMS / 2) run_phase();

        // long calm stretch: a larger table, then a few long scans
        calm = 1'b1;
        for (int i = 0; i < FILL; i++)
            send_plain(mk_word(spc_pkg::CMD_LOAD, 12'(i), 10'd7, 32'(i * 16), $urandom,
                               1'($urandom)));
        cfg_write(spc_pkg::REG_ENTRIES, 16'(FILL));
        for (int i = 0; i < 4; i++) begin
            send_plain(mk_word(spc_pkg::CMD_PROC, 12'($urandom), 10'd7,
                               32'($urandom_range(FILL * 16)),
                               32'($urandom_range(20, 3000)), 1'($urandom)));
            send_plain(mk_word(spc_pkg::CMD_LOOKUP, 12'($urandom), 10'd7,
                               32'($urandom_range(FILL - 1) * 16), $urandom, 1'($urandom)));
        end
        send_plain(mk_word(spc_pkg::CMD_LOOKUP, 12'd0, 10'd7, 32'd1, 32'd0, 1'b0));
        calm = 1'b0;

        while (words_sent < N_ITEMS) run_phase();

        drain();
        repeat (100) @(negedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS spanned_point_counter");
        end else begin
            $display("FAIL spanned_point_counter");
        end
        $finish;
    end

endmodule
